### hw/rtl/cubic_congestion_window_macros.svh
// assertion macros used by the cubic congestion window rtl
// no dependencies; included by modules that carry checks
`ifndef CUBIC_CONGESTION_WINDOW_MACROS_SVH
`define CUBIC_CONGESTION_WINDOW_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccw check failed");

// antecedent implies consequent in the next cycle
`define CCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccw check failed");

`endif

### hw/rtl/ccw_pkg.sv
// shared types and constants for the cubic congestion window block
// no dependencies
package ccw_pkg;

    typedef enum logic [2:0] {
        EV_ACK        = 3'd0,
        EV_LOSS       = 3'd1,
        EV_FAST_RETX  = 3'd2,
        EV_DUP_ACK    = 3'd3,
        EV_RECOV_ACK  = 3'd4,
        EV_SEND_QUERY = 3'd5,
        EV_RESET      = 3'd6
    } ccw_event_t;

    typedef enum logic [1:0] {
        CFG_MSS      = 2'd0,
        CFG_INIT_THR = 2'd1,
        CFG_BETA     = 2'd2,
        CFG_CSCALE   = 2'd3
    } ccw_cfg_idx_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] acked_bytes;
        logic [31:0] flight_bytes;
        logic [31:0] outstanding_bytes;
        logic [31:0] segment_bytes;
        logic        recovery_done;
    } ccw_in_t;

    typedef struct packed {
        logic [31:0] window_bytes;
        logic [31:0] threshold_bytes;
        logic [31:0] window_at_loss;
        logic        in_recovery;
        logic        send_allowed;
    } ccw_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NA,
        OP_MW,
        OP_CUR,
        OP_RAD,
        OP_INC,
        OP_OMB,
        OP_SQ,
        OP_CUBE,
        OP_DSQ,
        OP_DCUBE,
        OP_SCALE,
        OP_MSS
    } ccw_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_NA,
        S_DIV_MW,
        S_DIV_CUR,
        S_MUL_OMB,
        S_DIV_RAD,
        S_CB_SQ,
        S_CB_CUBE,
        S_CB_STEP,
        S_MUL_DSQ,
        S_MUL_DCUBE,
        S_MUL_SCALE,
        S_MUL_MSS,
        S_TARGET,
        S_DECIDE,
        S_DIV_INC,
        S_APPLY,
        S_OUT
    } ccw_state_t;

    typedef struct packed {
        logic    load_item;
        logic    exec;
        logic    unit_start;
        ccw_op_t op;
        logic    cb_init;
        logic    cb_step;
        logic    target;
        logic    apply;
        logic    out_load;
    } ccw_cmd_t;

    typedef struct packed {
        logic need_cubic;
        logic unit_done;
        logic bit_zero;
        logic diff_pos;
    } ccw_status_t;

    localparam logic [15:0] MSS_RST      = 16'd1460;
    localparam logic [31:0] INIT_THR_RST = 32'd65535;
    localparam logic [15:0] BETA_RST     = 16'd45875;
    localparam logic [23:0] CSCALE_RST   = 24'd26214;
    localparam logic [31:0] CWND_RST     = 32'd1460;
    localparam logic [31:0] SSTHRESH_RST = 32'd65535;
    localparam logic [31:0] MAX32        = 32'hFFFF_FFFF;

endpackage

### hw/rtl/ccw_mul.sv
// 64 x 64 multiplier built from one 32 x 32 multiplier, one partial product at a time
// no dependencies
module ccw_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod,
    output logic         done
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_idx_reg;
    logic [1:0]   cnt_reg;
    logic         run_reg;
    logic         pp_vld_reg;
    logic         done_reg;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [6:0]   pp_shift;

    assign a_part   = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_part   = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    // partial weight is 32 times the sum of the two half indexes
    assign pp_shift = {pp_idx_reg[1] & pp_idx_reg[0], pp_idx_reg[1] ^ pp_idx_reg[0], 5'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            cnt_reg    <= 2'd0;
            pp_vld_reg <= 1'b0;
            pp_idx_reg <= 2'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            pp_vld_reg <= run_reg;
            pp_idx_reg <= cnt_reg;
            done_reg   <= pp_vld_reg && (pp_idx_reg == 2'd3);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (pp_vld_reg)
        begin
            acc_reg <= acc_reg + (128'(pp_reg) << pp_shift);
        end
        pp_reg <= 64'(a_part) * 64'(b_part);
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

### hw/rtl/ccw_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module ccw_div #(
    parameter int NUM_W = 80,
    parameter int DEN_W = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], fits};
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;

endmodule

### hw/rtl/ccw_dp.sv
// datapath: window state, configuration registers and cubic arithmetic
// depends on ccw_pkg, ccw_mul and ccw_div
module ccw_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccw_pkg::ccw_cmd_t    cmd,
    output ccw_pkg::ccw_status_t status,
    input  ccw_pkg::ccw_in_t     req,
    output ccw_pkg::ccw_out_t    rsp,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int LIM_SHIFT = (40 + FRAC_BITS > 62) ? 62 : 40 + FRAC_BITS;
    localparam logic [63:0] LIM = (64'd1 << LIM_SHIFT) - 64'd1;
    localparam int NUM_W = 64 + FRAC_BITS;
    localparam int BIT_W = $clog2(14 + FRAC_BITS);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(13 + FRAC_BITS);
    localparam int UP16 = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN16 = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] inc);
        logic [63:0] room;
        room = 64'(ccw_pkg::MAX32 - a);
        if (inc >= room)
            sat_add = ccw_pkg::MAX32;
        else
            sat_add = a + inc[31:0];
    endfunction

    logic [15:0] mss_reg;
    logic [31:0] init_thr_reg;
    logic [15:0] beta_reg;
    logic [23:0] cscale_reg;

    logic [31:0] cwnd_reg, cwnd_next;
    logic [31:0] ssthresh_reg, ssthresh_next;
    logic [31:0] lwnd_reg, lwnd_next;
    logic        rec_reg, rec_next;
    logic        allowed_reg, allowed_next;

    ccw_pkg::ccw_in_t  item_reg;
    ccw_pkg::ccw_out_t rsp_reg;

    logic [63:0]      na_reg, mw_reg, cur_reg, x_reg, r_reg, s_reg, k_reg, tgt_reg;
    logic [BIT_W-1:0] bit_reg;

    logic [15:0]  seg_m;
    logic [63:0]  m_fx, cwnd_fx, lw_fx;
    logic [16:0]  omb17;
    logic [63:0]  omb, cq_raw, cq;
    logic [63:0]  t_val, mag, d_val, diff, inc_num, inc64;
    logic         d_neg;
    logic         diff_pos;
    logic         is_div;
    logic [NUM_W-1:0] div_num;
    logic [63:0]  div_den;
    logic [NUM_W-1:0] quo;
    logic         div_done;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] prod, prod_sh;
    logic         mul_done;
    logic [63:0]  fm, raw, qs;
    logic signed [65:0] tgt_base, tgt_t, tgt_sum;
    logic [63:0]  tgt_val;
    logic [31:0]  red_basis, red_cut, floor2, acked_min;
    logic [47:0]  red_prod;

    assign seg_m   = (mss_reg == 16'd0) ? 16'd1 : mss_reg;
    assign m_fx    = 64'(seg_m) << FRAC_BITS;
    assign cwnd_fx = 64'(cwnd_reg) << FRAC_BITS;
    assign lw_fx   = 64'(lwnd_reg) << FRAC_BITS;
    assign omb17   = 17'h10000 - {1'b0, beta_reg};
    assign omb     = (64'(omb17) << UP16) >> DN16;
    assign cq_raw  = (64'(cscale_reg) << UP16) >> DN16;
    assign cq      = (cq_raw == 64'd0) ? 64'd1 : cq_raw;
    assign t_val   = k_reg | (64'd1 << bit_reg);
    assign d_neg   = na_reg < k_reg;
    assign mag     = d_neg ? k_reg - na_reg : na_reg - k_reg;
    assign d_val   = (cur_reg < ONE_FX) ? ONE_FX : cur_reg;
    assign diff    = tgt_reg - cwnd_fx;
    assign diff_pos = tgt_reg > cwnd_fx;
    // ceiling division through a biased numerator
    assign inc_num = diff + d_val - 64'd1;
    assign inc64   = diff_pos ? x_reg : 64'd1;

    always_comb
    begin
        is_div  = 1'b0;
        div_num = '0;
        div_den = 64'd1;
        mul_a   = '0;
        mul_b   = '0;
        unique case (cmd.op) inside
            ccw_pkg::OP_NA, ccw_pkg::OP_MW, ccw_pkg::OP_CUR,
            ccw_pkg::OP_RAD, ccw_pkg::OP_INC: is_div = 1'b1;
            default: is_div = 1'b0;
        endcase
        unique case (cmd.op)
            ccw_pkg::OP_NA:
            begin
                div_num = NUM_W'(item_reg.acked_bytes) << FRAC_BITS;
                div_den = 64'(seg_m);
            end
            ccw_pkg::OP_MW:
            begin
                div_num = NUM_W'(lwnd_reg) << FRAC_BITS;
                div_den = 64'(seg_m);
            end
            ccw_pkg::OP_CUR:
            begin
                div_num = NUM_W'(cwnd_reg) << FRAC_BITS;
                div_den = 64'(seg_m);
            end
            ccw_pkg::OP_RAD:
            begin
                div_num = NUM_W'(x_reg) << FRAC_BITS;
                div_den = cq;
            end
            ccw_pkg::OP_INC:
            begin
                div_num = NUM_W'(inc_num);
                div_den = d_val;
            end
            ccw_pkg::OP_OMB:
            begin
                mul_a = mw_reg;
                mul_b = omb;
            end
            ccw_pkg::OP_SQ:
            begin
                mul_a = t_val;
                mul_b = t_val;
            end
            ccw_pkg::OP_CUBE:
            begin
                mul_a = s_reg;
                mul_b = t_val;
            end
            ccw_pkg::OP_DSQ:
            begin
                mul_a = mag;
                mul_b = mag;
            end
            ccw_pkg::OP_DCUBE:
            begin
                mul_a = s_reg;
                mul_b = mag;
            end
            ccw_pkg::OP_SCALE:
            begin
                mul_a = cq;
                mul_b = s_reg;
            end
            ccw_pkg::OP_MSS:
            begin
                mul_a = s_reg;
                mul_b = 64'(seg_m);
            end
            default:
            begin
                div_num = '0;
            end
        endcase
    end

    ccw_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.unit_start && !is_div),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    ccw_div #(
        .NUM_W (NUM_W),
        .DEN_W (64)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.unit_start && is_div),
        .num   (div_num),
        .den   (div_den),
        .quo   (quo),
        .done  (div_done)
    );

    // fixed point product truncates then saturates, raw product only saturates
    assign prod_sh = prod >> FRAC_BITS;
    assign fm  = (prod_sh > {64'd0, LIM}) ? LIM : prod_sh[63:0];
    assign raw = (prod > {64'd0, LIM}) ? LIM : prod[63:0];
    assign qs  = (quo > NUM_W'(LIM)) ? LIM : quo[63:0];

    always_comb
    begin
        tgt_base = $signed({2'b00, lw_fx});
        tgt_t    = $signed({2'b00, s_reg});
        tgt_sum  = d_neg ? tgt_base - tgt_t : tgt_base + tgt_t;
        if (tgt_sum > $signed({2'b00, LIM}))
            tgt_val = LIM;
        else if (tgt_sum < $signed({2'b00, m_fx}))
            tgt_val = m_fx;
        else
            tgt_val = tgt_sum[63:0];
    end

    assign red_basis = (item_reg.req_type == ccw_pkg::EV_FAST_RETX) ?
                       item_reg.flight_bytes : cwnd_reg;
    assign red_prod  = 48'(red_basis) * 48'(beta_reg);
    assign floor2    = {15'd0, seg_m, 1'b0};
    assign red_cut   = (red_prod[47:16] < floor2) ? floor2 : red_prod[47:16];
    assign acked_min = (item_reg.acked_bytes < 32'(seg_m)) ? item_reg.acked_bytes : 32'(seg_m);

    always_comb
    begin
        cwnd_next     = cwnd_reg;
        ssthresh_next = ssthresh_reg;
        lwnd_next     = lwnd_reg;
        rec_next      = rec_reg;
        allowed_next  = allowed_reg;
        if (cmd.exec)
        begin
            allowed_next = 1'b0;
            unique case (item_reg.req_type) inside
                ccw_pkg::EV_ACK:
                begin
                    if (item_reg.acked_bytes != 32'd0 && !rec_reg && cwnd_reg < ssthresh_reg)
                        cwnd_next = sat_add(cwnd_reg, 64'(acked_min));
                end
                ccw_pkg::EV_LOSS, ccw_pkg::EV_FAST_RETX:
                begin
                    lwnd_next     = cwnd_reg;
                    ssthresh_next = red_cut;
                    cwnd_next     = red_cut;
                    rec_next      = (item_reg.req_type == ccw_pkg::EV_FAST_RETX);
                end
                ccw_pkg::EV_DUP_ACK:
                begin
                    if (rec_reg)
                        cwnd_next = sat_add(cwnd_reg, 64'(seg_m));
                end
                ccw_pkg::EV_RECOV_ACK:
                begin
                    if (rec_reg && item_reg.recovery_done)
                    begin
                        cwnd_next = ssthresh_reg;
                        rec_next  = 1'b0;
                    end
                end
                ccw_pkg::EV_SEND_QUERY:
                begin
                    allowed_next = (item_reg.outstanding_bytes <= cwnd_reg) &&
                                   (item_reg.segment_bytes <= cwnd_reg - item_reg.outstanding_bytes);
                end
                ccw_pkg::EV_RESET:
                begin
                    cwnd_next     = 32'(seg_m);
                    ssthresh_next = (init_thr_reg > floor2) ? init_thr_reg : floor2;
                    lwnd_next     = 32'(seg_m);
                    rec_next      = 1'b0;
                end
                default:
                begin
                    allowed_next = 1'b0;
                end
            endcase
        end
        if (cmd.apply)
            cwnd_next = sat_add(cwnd_reg, inc64);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg      <= ccw_pkg::MSS_RST;
            init_thr_reg <= ccw_pkg::INIT_THR_RST;
            beta_reg     <= ccw_pkg::BETA_RST;
            cscale_reg   <= ccw_pkg::CSCALE_RST;
            cwnd_reg     <= ccw_pkg::CWND_RST;
            ssthresh_reg <= ccw_pkg::SSTHRESH_RST;
            lwnd_reg     <= ccw_pkg::CWND_RST;
            rec_reg      <= 1'b0;
            allowed_reg  <= 1'b0;
        end
        else
        begin
            cwnd_reg     <= cwnd_next;
            ssthresh_reg <= ssthresh_next;
            lwnd_reg     <= lwnd_next;
            rec_reg      <= rec_next;
            allowed_reg  <= allowed_next;
            if (cfg_valid)
            begin
                unique case (ccw_pkg::ccw_cfg_idx_t'(cfg_index))
                    ccw_pkg::CFG_MSS:      mss_reg      <= cfg_data[15:0];
                    ccw_pkg::CFG_INIT_THR: init_thr_reg <= cfg_data;
                    ccw_pkg::CFG_BETA:     beta_reg     <= cfg_data[15:0];
                    ccw_pkg::CFG_CSCALE:   cscale_reg   <= cfg_data[23:0];
                    default:               mss_reg      <= mss_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= req;
        if (cmd.out_load)
            rsp_reg <= '{window_bytes: cwnd_reg, threshold_bytes: ssthresh_reg,
                         window_at_loss: lwnd_reg, in_recovery: rec_reg,
                         send_allowed: allowed_reg};
        if (cmd.cb_init)
        begin
            k_reg   <= '0;
            bit_reg <= BIT_TOP;
        end
        else if (cmd.cb_step)
        begin
            // keep the trial bit when its cube stays within the radicand
            if (s_reg <= r_reg)
                k_reg <= t_val;
            if (bit_reg != '0)
                bit_reg <= bit_reg - BIT_W'(1);
        end
        if (cmd.target)
            tgt_reg <= tgt_val;
        if (div_done)
        begin
            unique case (cmd.op)
                ccw_pkg::OP_NA:  na_reg  <= qs;
                ccw_pkg::OP_MW:  mw_reg  <= qs;
                ccw_pkg::OP_CUR: cur_reg <= qs;
                ccw_pkg::OP_RAD: r_reg   <= qs;
                ccw_pkg::OP_INC: x_reg   <= quo[63:0];
                default:         r_reg   <= r_reg;
            endcase
        end
        if (mul_done)
        begin
            unique case (cmd.op)
                ccw_pkg::OP_OMB: x_reg <= fm;
                ccw_pkg::OP_MSS: s_reg <= raw;
                default:         s_reg <= fm;
            endcase
        end
    end

    assign status.need_cubic = (item_reg.req_type == ccw_pkg::EV_ACK) &&
                               (item_reg.acked_bytes != 32'd0) && !rec_reg &&
                               (cwnd_reg >= ssthresh_reg);
    assign status.unit_done  = div_done || mul_done;
    assign status.bit_zero   = (bit_reg == '0);
    assign status.diff_pos   = diff_pos && (diff != 64'd0);
    assign rsp = rsp_reg;

endmodule

### hw/rtl/ccw_ctrl.sv
// controller state machine that sequences one event through the datapath
// depends on ccw_pkg and cubic_congestion_window_macros.svh
`include "cubic_congestion_window_macros.svh"
module ccw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ccw_pkg::ccw_cmd_t    cmd,
    input  ccw_pkg::ccw_status_t status
);

    ccw_pkg::ccw_state_t state_reg, state_next;
    ccw_pkg::ccw_state_t unit_follow;
    ccw_pkg::ccw_op_t    unit_op;
    logic                unit_state;
    logic                launched_reg, launched_next;
    logic                rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ccw_pkg::S_IDLE;
            launched_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        cmd.op         = ccw_pkg::OP_NONE;
        unit_state     = 1'b0;
        unit_op        = ccw_pkg::OP_NONE;
        unit_follow    = ccw_pkg::S_IDLE;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        unique case (state_reg)
            ccw_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ccw_pkg::S_EXEC;
                end
            end
            ccw_pkg::S_EXEC:
            begin
                cmd.exec    = 1'b1;
                cmd.cb_init = 1'b1;
                state_next  = status.need_cubic ? ccw_pkg::S_DIV_NA : ccw_pkg::S_OUT;
            end
            ccw_pkg::S_DIV_NA:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_NA;
                unit_follow = ccw_pkg::S_DIV_MW;
            end
            ccw_pkg::S_DIV_MW:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_MW;
                unit_follow = ccw_pkg::S_DIV_CUR;
            end
            ccw_pkg::S_DIV_CUR:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_CUR;
                unit_follow = ccw_pkg::S_MUL_OMB;
            end
            ccw_pkg::S_MUL_OMB:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_OMB;
                unit_follow = ccw_pkg::S_DIV_RAD;
            end
            ccw_pkg::S_DIV_RAD:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_RAD;
                unit_follow = ccw_pkg::S_CB_SQ;
            end
            ccw_pkg::S_CB_SQ:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_SQ;
                unit_follow = ccw_pkg::S_CB_CUBE;
            end
            ccw_pkg::S_CB_CUBE:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_CUBE;
                unit_follow = ccw_pkg::S_CB_STEP;
            end
            ccw_pkg::S_CB_STEP:
            begin
                cmd.cb_step = 1'b1;
                state_next  = status.bit_zero ? ccw_pkg::S_MUL_DSQ : ccw_pkg::S_CB_SQ;
            end
            ccw_pkg::S_MUL_DSQ:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_DSQ;
                unit_follow = ccw_pkg::S_MUL_DCUBE;
            end
            ccw_pkg::S_MUL_DCUBE:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_DCUBE;
                unit_follow = ccw_pkg::S_MUL_SCALE;
            end
            ccw_pkg::S_MUL_SCALE:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_SCALE;
                unit_follow = ccw_pkg::S_MUL_MSS;
            end
            ccw_pkg::S_MUL_MSS:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_MSS;
                unit_follow = ccw_pkg::S_TARGET;
            end
            ccw_pkg::S_TARGET:
            begin
                cmd.target = 1'b1;
                state_next = ccw_pkg::S_DECIDE;
            end
            ccw_pkg::S_DECIDE:
            begin
                // target at or below the window grows it by one byte
                if (status.diff_pos)
                    state_next = ccw_pkg::S_DIV_INC;
                else
                begin
                    cmd.apply  = 1'b1;
                    state_next = ccw_pkg::S_OUT;
                end
            end
            ccw_pkg::S_DIV_INC:
            begin
                unit_state  = 1'b1;
                unit_op     = ccw_pkg::OP_INC;
                unit_follow = ccw_pkg::S_APPLY;
            end
            ccw_pkg::S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ccw_pkg::S_OUT;
            end
            ccw_pkg::S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ccw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ccw_pkg::S_IDLE;
            end
        endcase
        // one unit operation per state: launch once, advance on done
        if (unit_state)
        begin
            cmd.op         = unit_op;
            cmd.unit_start = !launched_reg;
            launched_next  = 1'b1;
            if (status.unit_done)
            begin
                launched_next = 1'b0;
                state_next    = unit_follow;
            end
        end
    end

    assign req_stall = (state_reg != ccw_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `CCW_ASSERT_NXT(a_accept_exec, clk, rst_n, req_valid && !req_stall, state_reg == ccw_pkg::S_EXEC)
    `CCW_ASSERT_IMP(a_rsp_from_out, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == ccw_pkg::S_OUT)
    `CCW_ASSERT_IMP(a_done_launched, clk, rst_n, status.unit_done, launched_reg)

endmodule

### hw/rtl/cubic_congestion_window.sv
// a congestion-avoidance ack runs the bit-serial divider, the multiplier and the cube root loop
// before the result is registered, with one divide fewer when the target does not exceed
// the window; other events update the window state and go straight to the output register
// throughput: one item in flight, the next is taken once the result sits in the output register
// reset: asynchronous, restores register defaults and the initial window state
// depends on ccw_pkg, ccw_ctrl and ccw_dp
module cubic_congestion_window #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ccw_pkg::ccw_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ccw_pkg::ccw_out_t rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    ccw_pkg::ccw_cmd_t    cmd;
    ccw_pkg::ccw_status_t status;

    assign cfg_ready = 1'b1;

    ccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    ccw_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req),
        .rsp       (rsp),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
